// File: src/pcpfl_pkg.sv
package pcpfl_pkg;

    localparam int CPU_ID_W  = 4;
    localparam int PAGE_ID_W = 20;
    localparam int COUNT_W   = 32;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOMEM   = 2'd1;
    localparam logic [1:0] STATUS_BADADDR = 2'd2;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_TOP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP
    } state_t;

    typedef struct packed {
        logic                 found;
        logic [CPU_ID_W-1:0]  src;
        logic [PAGE_ID_W-1:0] src_head;
        logic                 own_nonempty;
        logic [PAGE_ID_W-1:0] own_head;
    } heads_view_t;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [CPU_ID_W-1:0]  cpu;
        logic [PAGE_ID_W-1:0] idx;
        logic [PAGE_ID_W-1:0] link;
    } heads_cmd_t;

endpackage

// File: src/pcpfl_ram.sv
module pcpfl_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pcpfl_check.sv
module pcpfl_check #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_W     = 15
) (
    input  logic [31:0]       addr,
    input  logic [31:0]       base,
    input  logic [31:0]       top,
    output logic              bad,
    output logic [PAGE_W-1:0] idx
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_FULL_W = 32 - PAGE_SHIFT;

    logic [31:0]           origin;
    logic [31:0]           offset;
    logic [IDX_FULL_W-1:0] idx_full;
    logic                  misaligned;
    logic                  over;

    always_comb
    begin
        origin     = base & ~32'(PAGE_BYTES - 1);
        offset     = addr - origin;
        idx_full   = offset[31:PAGE_SHIFT];
        misaligned = addr[PAGE_SHIFT-1:0] != '0;
        over       = 32'(idx_full) >= 32'(NUM_PAGES);
        bad        = misaligned || (addr < base) || (addr >= top) || over;
        idx        = PAGE_W'(idx_full);
    end

endmodule

// File: src/pcpfl_heads.sv
module pcpfl_heads
    import pcpfl_pkg::*;
#(
    parameter int NUM_CPUS = 8,
    parameter int PAGE_W   = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CPU_ID_W-1:0] req_cpu,
    input  heads_cmd_t          cmd,
    output heads_view_t         view
);

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [PAGE_W-1:0]  head_reg  [NUM_CPUS];
    logic [COUNT_W-1:0] count_reg [NUM_CPUS];
    logic [CPU_W-1:0]   own;
    logic [CPU_W-1:0]   src;
    logic [CPU_W-1:0]   upd;
    logic               found;

    always_comb
    begin
        own   = req_cpu[CPU_W-1:0];
        upd   = cmd.cpu[CPU_W-1:0];
        found = 1'b0;
        src   = '0;
        for (int c = NUM_CPUS - 1; c >= 0; c--)
        begin
            if (count_reg[c] != '0)
            begin
                found = 1'b1;
                src   = CPU_W'(c);
            end
        end
        if (count_reg[own] != '0)
        begin
            src = own;
        end
        view.found        = found;
        view.src          = CPU_ID_W'(src);
        view.src_head     = PAGE_ID_W'(head_reg[src]);
        view.own_nonempty = count_reg[own] != '0;
        view.own_head     = PAGE_ID_W'(head_reg[own]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end
        else if (cmd.push)
        begin
            head_reg[upd]  <= cmd.idx[PAGE_W-1:0];
            count_reg[upd] <= count_reg[upd] + COUNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_reg[upd] <= count_reg[upd] - COUNT_W'(1);
            head_reg[upd]  <= (count_reg[upd] == COUNT_W'(1)) ? '0 : cmd.link[PAGE_W-1:0];
        end
    end

endmodule

// File: src/per_cpu_page_free_list.sv
// Page allocator with one last-in first-out free list per CPU.
// Requests arrive on the in channel (in_valid/in_ready) as one word holding
// func, cpu and page_addr. A free pushes the page onto the list of that CPU
// after checking it against the pool window; an allocate pops the own list
// or, when that is empty, the lowest-numbered non-empty list of another CPU.
// Every request gives exactly one result word on the out channel
// (out_valid/out_ready): status, alloc_addr and stolen.
// A free or an out-of-memory allocate loads the result register in the execute
// state; a successful allocate goes on to the pop state, because the link below
// the popped page is read from the link memory, whose read is registered, before
// the list head is updated. One request is in flight at a time, so the block
// accepts no new word until the last one has loaded its result.
// The pool window registers are written through cfg_we/cfg_index/cfg_data.
// Reset empties every list and clears the window registers; the link memory
// needs no clearing. When the receiver stalls, the finished result waits in
// the output register, the next request is still accepted, and its work
// holds before its result would be written until the register frees up.
module per_cpu_page_free_list
    import pcpfl_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [2:0]  cpu,
    input  logic [31:0] page_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] alloc_addr,
    output logic        stolen
);

    localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    state_t             state_reg;
    state_t             state_next;
    logic [31:0]        base_reg;
    logic [31:0]        top_reg;
    logic               req_func_reg;
    logic [CPU_W-1:0]   req_cpu_reg;
    logic [31:0]        req_addr_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [31:0]        alloc_addr_reg;
    logic               stolen_reg;

    logic               out_free;
    logic               is_alloc;
    logic               chk_bad;
    logic [PAGE_W-1:0]  chk_idx;
    heads_view_t        view;
    heads_cmd_t         cmd;
    logic               ram_we;
    logic               ram_re;
    logic [PAGE_W-1:0]  ram_wdata;
    logic [PAGE_W-1:0]  ram_rdata;
    logic               result_load;
    logic [1:0]         res_status;
    logic [31:0]        res_addr;
    logic               res_stolen;
    logic [31:0]        origin;
    logic [CPU_W-1:0]   cpu_mod;

    pcpfl_check #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_W     (PAGE_W)
    ) u_check (
        .addr (req_addr_reg),
        .base (base_reg),
        .top  (top_reg),
        .bad  (chk_bad),
        .idx  (chk_idx)
    );

    pcpfl_heads #(
        .NUM_CPUS (NUM_CPUS),
        .PAGE_W   (PAGE_W)
    ) u_heads (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_cpu (CPU_ID_W'(req_cpu_reg)),
        .cmd     (cmd),
        .view    (view)
    );

    pcpfl_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chk_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (view.src_head[PAGE_W-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign is_alloc = req_func_reg == FUNC_ALLOC;
    assign origin   = base_reg & ~32'(PAGE_BYTES - 1);

    always_comb
    begin
        cpu_mod = '0;
        for (int v = 0; v < 8; v++)
        begin
            if (cpu == 3'(v))
            begin
                cpu_mod = CPU_W'(v % NUM_CPUS);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_alloc && view.found)
                begin
                    state_next = ST_POP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        ram_re      = 1'b0;
        result_load = 1'b0;
        cmd         = '0;
        res_status  = STATUS_OK;
        res_addr    = '0;
        res_stolen  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                if (is_alloc)
                begin
                    ram_re = view.found;
                    if (!view.found)
                    begin
                        result_load = out_free;
                        res_status  = STATUS_NOMEM;
                    end
                end
                else
                begin
                    result_load = out_free;
                    cmd.push    = out_free && !chk_bad;
                    cmd.cpu     = CPU_ID_W'(req_cpu_reg);
                    cmd.idx     = PAGE_ID_W'(chk_idx);
                    res_status  = chk_bad ? STATUS_BADADDR : STATUS_OK;
                end
            end
            ST_POP:
            begin
                result_load = out_free;
                cmd.pop     = out_free;
                cmd.cpu     = view.src;
                cmd.link    = PAGE_ID_W'(ram_rdata);
                res_status  = STATUS_OK;
                res_addr    = origin + (32'(view.src_head[PAGE_W-1:0]) << PAGE_SHIFT);
                res_stolen  = view.src != CPU_ID_W'(req_cpu_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign ram_we    = cmd.push;
    assign ram_wdata = view.own_nonempty ? view.own_head[PAGE_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POOL_BASE: base_reg <= cfg_data;
                    CFG_POOL_TOP:  top_reg  <= cfg_data;
                    default:       base_reg <= base_reg;
                endcase
            end
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_func_reg <= func;
            req_cpu_reg  <= cpu_mod;
            req_addr_reg <= page_addr;
        end
        if (result_load)
        begin
            status_reg     <= res_status;
            alloc_addr_reg <= res_addr;
            stolen_reg     <= res_stolen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign alloc_addr = alloc_addr_reg;
    assign stolen     = stolen_reg;

    a_link_port_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re)
    ) else $error("Link memory written and read in the same cycle.");

    a_pop_has_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> view.found
    ) else $error("Pop in progress without a non-empty list.");

    a_result_slot_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_load |-> (!out_valid_reg || out_ready)
    ) else $error("Result word overwrites one not yet taken.");

    a_accept_starts_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC)
    ) else $error("Accepted word did not start execution.");

    a_pop_after_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_POP) |-> $past(ram_re)
    ) else $error("Pop entered without a link read.");

endmodule
